### sv/htwd_pkg.sv
// ============================================================================
// htwd_pkg
// Shared types and constants for the Huffman tree-walk decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package htwd_pkg;

  localparam int IDX_W      = 9;   // node index width
  localparam int SYM_W      = 8;   // symbol width
  localparam int BYTE_W     = 8;   // compressed byte width
  localparam int CNT_W      = 4;   // bit count width
  localparam int ACT_W      = 2;   // action code width

  localparam int NODE_COUNT = 512; // node table depth
  localparam int NODE_AW    = $clog2(NODE_COUNT);

  localparam int CMDQ_DEPTH = 2;   // command queue between front and back
  localparam int CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DECODE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_DECODE,
    CMD_RESTART
  } cmd_kind_t;

  // one node table entry, 29 bits
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic             left_pres;
    logic [IDX_W-1:0] right;
    logic             right_pres;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  localparam int ENTRY_W = $bits(node_t);

  // classified command handed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  node_index;
    node_t             node;
    logic [BYTE_W-1:0] code_byte;
    logic [CNT_W-1:0]  bit_cnt;   // already clamped to 1..BYTE_W
  } cmd_t;

endpackage

`default_nettype wire

### sv/htwd_front.sv
// ============================================================================
// htwd_front
// Accepts input items, classifies them and queues commands for the walker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module htwd_front
  import htwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [IDX_W-1:0]  in_node_index,
  input  wire logic [IDX_W-1:0]  in_left_child,
  input  wire logic              in_left_present,
  input  wire logic [IDX_W-1:0]  in_right_child,
  input  wire logic              in_right_present,
  input  wire logic              in_leaf_mark,
  input  wire logic [SYM_W-1:0]  in_leaf_symbol,
  input  wire logic [BYTE_W-1:0] in_code_byte,
  input  wire logic [CNT_W-1:0]  in_bit_count,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  wire logic              cmd_pop
);

  cmd_t               q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_r, wptr_nxt;
  logic [CMDQ_AW-1:0] rptr_r, rptr_nxt;
  logic [CMDQ_CW-1:0] cnt_r, cnt_nxt;

  cmd_t               cmd_in;
  logic               keep;
  logic               enq;
  logic               deq;

  // classify: items with no effect (unused code, empty byte, write off the
  // table) are dropped here
  always_comb begin
    cmd_in            = '0;
    cmd_in.node_index = in_node_index;
    cmd_in.node       = '{left: in_left_child, left_pres: in_left_present,
                          right: in_right_child, right_pres: in_right_present,
                          leaf: in_leaf_mark, sym: in_leaf_symbol};
    cmd_in.code_byte  = in_code_byte;
    cmd_in.bit_cnt    = (in_bit_count > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W) : in_bit_count;
    keep              = 1'b0;
    case (in_action)
      ACT_WRITE: begin
        cmd_in.kind = CMD_WRITE;
        keep        = (32'(in_node_index) < NODE_COUNT);
      end
      ACT_DECODE: begin
        cmd_in.kind = CMD_DECODE;
        keep        = (in_bit_count != '0);
      end
      ACT_RESTART: begin
        cmd_in.kind = CMD_RESTART;
        keep        = 1'b1;
      end
      default: begin
        cmd_in.kind = CMD_RESTART;
        keep        = 1'b0;
      end
    endcase
  end

  assign in_full   = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rptr_r];
  assign enq       = in_push && !in_full && keep;
  assign deq       = cmd_pop && cmd_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (enq) begin
      wptr_nxt = (wptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (deq) begin
      rptr_nxt = (rptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wptr_r] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CMDQ_CW'(CMDQ_DEPTH))
    else $error("command queue over-filled");
`endif

endmodule

`default_nettype wire

### sv/htwd_walk.sv
// ============================================================================
// htwd_walk
// Back end: node table, bit-by-bit tree walk and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module htwd_walk
  import htwd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  input  wire logic             cmd_valid,
  input  wire cmd_t             cmd,
  output logic                  cmd_pop,
  output logic                  out_vld,
  output logic [SYM_W-1:0]      out_sym,
  output logic                  out_last,
  input  wire logic             out_pop
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_CHECK,
    S_FLUSH
  } state_t;

  node_t              mem [NODE_COUNT];
  node_t              rdata_r;
  logic               rd_oob_r;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  node_t              ent;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   root_r, root_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [SYM_W-1:0]   pend_sym_r, pend_sym_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;

  logic               slot_free;
  logic               out_take;
  logic               push;
  logic [SYM_W-1:0]   push_sym;
  logic               push_last;
  logic               bit_in;
  logic [IDX_W-1:0]   step_pos;

  // an index off the table reads as an empty node
  assign ent       = rd_oob_r ? node_t'('0) : rdata_r;
  assign out_take  = out_pop && out_vld_r;
  assign slot_free = !out_vld_r || out_take;

  assign bit_in    = byte_r[BYTE_W-1];
  always_comb begin
    step_pos = pos_r;
    if (bit_in) begin
      if (ent.right_pres) step_pos = ent.right;
    end else begin
      if (ent.left_pres) step_pos = ent.left;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    root_nxt     = cfg_we ? cfg_wdata : root_r;
    pos_nxt      = pos_r;
    byte_nxt     = byte_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_sym_nxt = pend_sym_r;
    raddr        = pos_r;
    we           = 1'b0;
    cmd_pop      = 1'b0;
    push         = 1'b0;
    push_sym     = pend_sym_r;
    push_last    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_WRITE:   we = 1'b1;
            CMD_RESTART: pos_nxt = root_r;
            CMD_DECODE: begin
              byte_nxt  = cmd.code_byte;
              cnt_nxt   = cmd.bit_cnt;
              state_nxt = S_STEP;
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        pos_nxt   = step_pos;
        raddr     = step_pos;
        byte_nxt  = byte_r << 1;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (ent.leaf) begin
          if (!pend_vld_r || slot_free) begin
            push         = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_sym_nxt = ent.sym;
            pos_nxt      = root_r;
            raddr        = root_r;
            state_nxt    = (cnt_r == '0) ? S_FLUSH : S_STEP;
          end
        end else if (cnt_r == '0) begin
          state_nxt = S_FLUSH;
        end else begin
          pos_nxt  = step_pos;
          raddr    = step_pos;
          byte_nxt = byte_r << 1;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_sym_nxt  = out_sym_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_vld_nxt  = 1'b1;
      out_sym_nxt  = push_sym;
      out_last_nxt = push_last;
    end else if (out_take) begin
      out_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      root_r     <= '0;
      pos_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      root_r     <= root_nxt;
      pos_r      <= pos_nxt;
      byte_r     <= byte_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_sym_r <= pend_sym_nxt;
      out_vld_r  <= out_vld_nxt;
      out_sym_r  <= out_sym_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[NODE_AW'(cmd.node_index)] <= cmd.node;
    end
    rdata_r  <= mem[NODE_AW'(raddr)];
    rd_oob_r <= (32'(raddr) >= NODE_COUNT);
  end

  assign out_vld  = out_vld_r;
  assign out_sym  = out_sym_r;
  assign out_last = out_last_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_vld_r) |-> out_pop)
    else $error("result register overwritten");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("pending symbol left over at end of byte");
  a_step_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (cnt_r != '0))
    else $error("bit step with no bits left");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (cmd_valid && state_r == S_IDLE))
    else $error("command taken while busy");
`endif

endmodule

`default_nettype wire

### sv/huffman_tree_walk_decoder_top.sv
// ============================================================================
// huffman_tree_walk_decoder_top
// Huffman decoder walking a stored code tree, queue-style ports.
// ============================================================================
// Items enter through a two-deep command queue, so a new item is taken while
// the walker is busy and while a symbol waits on the result ports, as long
// as the queue is not full. Items with action code 3, decode items with a zero
// bit count and node writes off the table are dropped on entry. A node write or
// a restart is handled by the walker in its idle state. A decode item goes
// through take, first step, one check per bit and a closing state, with an
// extra step for each leaf reached before its last bit, and waits while the
// result register has not drained. The walk is paced by the node table: each
// code bit needs one registered read whose address is the child chosen by the
// previous bit. The last symbol of each byte is held back one step so that it
// leaves with run_last set. root_node is written through cfg_we / cfg_wdata
// and is picked up at the next restart or leaf; write it only while the block
// is idle. The table has no reset: every node a walk can reach must be written
// first.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_walk_decoder_top
  import htwd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input item queue
  input  wire logic              push,
  output logic                   full,
  input  wire logic [ACT_W-1:0]  in_action,
  input  wire logic [IDX_W-1:0]  in_node_index,
  input  wire logic [IDX_W-1:0]  in_left_child,
  input  wire logic              in_left_present,
  input  wire logic [IDX_W-1:0]  in_right_child,
  input  wire logic              in_right_present,
  input  wire logic              in_leaf_mark,
  input  wire logic [SYM_W-1:0]  in_leaf_symbol,
  input  wire logic [BYTE_W-1:0] in_code_byte,
  input  wire logic [CNT_W-1:0]  in_bit_count,
  // result item queue
  output logic                   empty,
  input  wire logic              pop,
  output logic [SYM_W-1:0]       out_symbol,
  output logic                   out_run_last,
  // root node register
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_wdata
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic out_vld;

  // front: classify and queue
  htwd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (push),
    .in_full          (full),
    .in_action        (in_action),
    .in_node_index    (in_node_index),
    .in_left_child    (in_left_child),
    .in_left_present  (in_left_present),
    .in_right_child   (in_right_child),
    .in_right_present (in_right_present),
    .in_leaf_mark     (in_leaf_mark),
    .in_leaf_symbol   (in_leaf_symbol),
    .in_code_byte     (in_code_byte),
    .in_bit_count     (in_bit_count),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  // back: node table and walk
  htwd_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_vld   (out_vld),
    .out_sym   (out_symbol),
    .out_last  (out_run_last),
    .out_pop   (pop)
  );

  assign empty = !out_vld;

endmodule

`default_nettype wire
